// File: design/fwctr_pkg.sv
package fwctr_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int OFF_W      = 5;
  localparam int SIB_W      = 4;
  localparam int POL_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // Widest set index the registers can ask for (set_index_bits is at most 15).
  localparam int RAW_W      = 15;
  // The reduction modulo the set count takes a quotient step and a remainder step.
  localparam int MOD_STEPS  = 2;
  localparam int STEP_W     = 1;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd2;

  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_LRU  = 2'd1;
  localparam logic [POL_W-1:0] POL_LIFO = 2'd2;

  localparam logic [OFF_W-1:0] OFFSET_RESET = 5'd4;
  localparam logic [SIB_W-1:0] INDEX_RESET  = 4'd6;

  typedef struct packed {
    logic accept;    // latch the address of a new request
    logic mod_step;  // one step of the set index reduction
    logic read;      // read the tag row and order row of the set
    logic update;    // write back the set and load the result register
    logic clr_wr;    // clear one order row during the pass after reset
  } cmd_t;

  typedef struct packed {
    logic clr_done;  // the clearing counter is at the last set
  } status_t;

endpackage

// File: design/fwctr_ram.sv
module fwctr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/fwctr_ctrl.sv
module fwctr_ctrl #(
  parameter int NUM_SETS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  fwctr_pkg::status_t status_i,
  output fwctr_pkg::cmd_t    cmd_o
);

  localparam bit SetsPow2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_READ,
    S_UPDATE
  } state_e;

  state_e                        state_q;
  logic [fwctr_pkg::STEP_W-1:0]  step_q;
  logic                          out_vld_q;
  logic                          accept;
  logic                          fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_ready_o && in_valid_i;
  // The result register may be reloaded when it is empty or drains this cycle.
  assign fire        = (state_q == S_UPDATE) && (!out_vld_q || out_ready_i);
  assign out_valid_o = out_vld_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.mod_step = (state_q == S_MOD);
    cmd_o.read     = (state_q == S_READ);
    cmd_o.update   = fire;
    cmd_o.clr_wr   = (state_q == S_CLEAR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      step_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (status_i.clr_done) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            step_q  <= '0;
            state_q <= SetsPow2 ? S_READ : S_MOD;
          end
        end
        S_MOD: begin
          step_q <= step_q + 1'b1;
          if (step_q == fwctr_pkg::STEP_W'(fwctr_pkg::MOD_STEPS - 1)) begin
            state_q <= S_READ;
          end
        end
        S_READ: begin
          state_q <= S_UPDATE;
        end
        S_UPDATE: begin
          if (fire) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

endmodule

// File: design/fwctr_dp.sv
module fwctr_dp #(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [fwctr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fwctr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [fwctr_pkg::ADDR_W-1:0]         address_i,
  input  fwctr_pkg::cmd_t                      cmd_i,
  output fwctr_pkg::status_t                   status_o,
  output logic                                 evicted_o,
  output logic [fwctr_pkg::TAG_W-1:0]          victim_tag_o
);

  localparam bit SetsPow2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);
  localparam int SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RANK_W   = $clog2(NUM_WAYS);
  localparam int CNT_W    = $clog2(NUM_WAYS + 1);
  localparam int ORD_W    = CNT_W + NUM_WAYS * RANK_W;
  localparam int TROW_W   = NUM_WAYS * fwctr_pkg::TAG_W;

  localparam int     RCP_W    = 17;
  localparam int     PROD_W   = fwctr_pkg::RAW_W + RCP_W;
  localparam int     RECIP_SH = fwctr_pkg::RAW_W + SET_W;
  // Reciprocal of the set count rounded up; with this shift the quotient is
  // exact for every raw index.
  localparam longint RECIP    = ((longint'(1) << RECIP_SH) + NUM_SETS - 1) / NUM_SETS;

  // Configuration registers.
  logic [fwctr_pkg::OFF_W-1:0] off_q;
  logic [fwctr_pkg::SIB_W-1:0] sib_q;
  logic [fwctr_pkg::POL_W-1:0] pol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= fwctr_pkg::OFFSET_RESET;
      sib_q <= fwctr_pkg::INDEX_RESET;
      pol_q <= fwctr_pkg::POL_FIFO;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fwctr_pkg::REG_OFFSET_BITS: off_q <= cfg_data_i;
        fwctr_pkg::REG_INDEX_BITS:  sib_q <= cfg_data_i[fwctr_pkg::SIB_W-1:0];
        fwctr_pkg::REG_POLICY:      pol_q <= cfg_data_i[fwctr_pkg::POL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Address split.
  logic [fwctr_pkg::ADDR_W-1:0] idx_full;
  logic [5:0]                   tag_sh;
  logic [fwctr_pkg::TAG_W-1:0]  tag_new;

  assign idx_full = (address_i >> off_q) & ((32'd1 << sib_q) - 32'd1);
  assign tag_sh   = {1'b0, off_q} + {2'b00, sib_q};
  assign tag_new  = tag_sh[5] ? '0 : (address_i >> tag_sh[4:0]);

  logic [fwctr_pkg::TAG_W-1:0] tag_q;
  logic [fwctr_pkg::RAW_W-1:0] raw_q;
  logic [fwctr_pkg::RAW_W-1:0] quo_q;
  logic [SET_W:0]              rem_q;
  logic [PROD_W-1:0]           quo_prod;
  logic [PROD_W-1:0]           quo_sh;
  logic [PROD_W-1:0]           rem_full;

  // Raw index modulo the set count by reciprocal multiplication.
  assign quo_prod = PROD_W'(raw_q) * PROD_W'(RECIP);
  assign quo_sh   = quo_prod >> RECIP_SH;
  assign rem_full = PROD_W'(raw_q) - PROD_W'(quo_q) * PROD_W'(NUM_SETS);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      tag_q <= tag_new;
      raw_q <= idx_full[fwctr_pkg::RAW_W-1:0];
      rem_q <= SetsPow2 ? (SET_W+1)'(idx_full & 32'(NUM_SETS - 1)) : '0;
    end else if (cmd_i.mod_step) begin
      // The first step forms the quotient, the second the remainder from it.
      quo_q <= quo_sh[fwctr_pkg::RAW_W-1:0];
      rem_q <= rem_full[SET_W:0];
    end
  end

  // Clearing pass over the order rows.
  logic [SET_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_wr) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign status_o.clr_done = (clr_cnt_q == SET_W'(NUM_SETS - 1));

  // Set storage.
  logic [SET_W-1:0]  set_addr;
  logic [ORD_W-1:0]  ord_row;
  logic [ORD_W-1:0]  ord_new;
  logic [TROW_W-1:0] tag_row;
  logic [TROW_W-1:0] tag_row_new;

  assign set_addr = rem_q[SET_W-1:0];

  fwctr_ram #(
    .WIDTH (ORD_W),
    .DEPTH (NUM_SETS)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr_wr | cmd_i.update),
    .waddr_i (cmd_i.clr_wr ? clr_cnt_q : set_addr),
    .wdata_i (cmd_i.clr_wr ? '0 : ord_new),
    .re_i    (cmd_i.read),
    .raddr_i (set_addr),
    .rdata_o (ord_row)
  );

  fwctr_ram #(
    .WIDTH (TROW_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.update),
    .waddr_i (set_addr),
    .wdata_i (tag_row_new),
    .re_i    (cmd_i.read),
    .raddr_i (set_addr),
    .rdata_o (tag_row)
  );

  // Lookup and replacement. The valid ways of a set always form a prefix,
  // so one fill count per set stands in for the per-way valid bits.
  logic [CNT_W-1:0]            cnt;
  logic [CNT_W-1:0]            cnt_new;
  logic [RANK_W-1:0]           rank     [NUM_WAYS];
  logic [RANK_W-1:0]           rank_new [NUM_WAYS];
  logic [fwctr_pkg::TAG_W-1:0] tags     [NUM_WAYS];
  logic [fwctr_pkg::TAG_W-1:0] tags_new [NUM_WAYS];
  logic [NUM_WAYS-1:0]         way_vld;
  logic [NUM_WAYS-1:0]         match;
  logic [RANK_W-1:0]           hit_way;
  logic [RANK_W-1:0]           victim;
  logic [RANK_W-1:0]           want;
  logic [RANK_W-1:0]           fill_way;
  logic                        do_newest;
  logic [RANK_W-1:0]           nw_way;
  logic [RANK_W-1:0]           nw_top;
  logic [RANK_W-1:0]           old_rank;
  logic                        evict;
  logic [fwctr_pkg::TAG_W-1:0] vtag;

  always_comb begin
    cnt = ord_row[CNT_W-1:0];
    for (int i = 0; i < NUM_WAYS; i++) begin
      rank[i]    = ord_row[CNT_W + i*RANK_W +: RANK_W];
      tags[i]    = tag_row[i*fwctr_pkg::TAG_W +: fwctr_pkg::TAG_W];
      way_vld[i] = (cnt > CNT_W'(i));
      match[i]   = way_vld[i] && (tags[i] == tag_q);
    end

    want     = (pol_q == fwctr_pkg::POL_LIFO) ? RANK_W'(NUM_WAYS - 1) : '0;
    hit_way  = '0;
    victim   = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_way = RANK_W'(i);
      end
      if (rank[i] == want) begin
        victim = RANK_W'(i);
      end
    end
    fill_way = cnt[RANK_W-1:0];

    rank_new  = rank;
    tags_new  = tags;
    cnt_new   = cnt;
    do_newest = 1'b0;
    nw_way    = '0;
    nw_top    = '0;
    evict     = 1'b0;
    vtag      = '0;

    if (|match) begin
      if (pol_q == fwctr_pkg::POL_LRU) begin
        do_newest = 1'b1;
        nw_way    = hit_way;
        nw_top    = RANK_W'(cnt - 1'b1);
      end
    end else if (cnt < CNT_W'(NUM_WAYS)) begin
      // Fill of the first empty way; it is the newest and nothing ranks above.
      tags_new[fill_way] = tag_q;
      rank_new[fill_way] = fill_way;
      cnt_new            = cnt + 1'b1;
    end else if (pol_q == fwctr_pkg::POL_FIFO || pol_q == fwctr_pkg::POL_LRU ||
                 pol_q == fwctr_pkg::POL_LIFO) begin
      evict            = 1'b1;
      vtag             = tags[victim];
      tags_new[victim] = tag_q;
      do_newest        = 1'b1;
      nw_way           = victim;
      nw_top           = RANK_W'(NUM_WAYS - 1);
    end

    old_rank = rank[nw_way];
    if (do_newest) begin
      for (int i = 0; i < NUM_WAYS; i++) begin
        if ((RANK_W'(i) != nw_way) && way_vld[i] && (rank[i] > old_rank)) begin
          rank_new[i] = rank[i] - 1'b1;
        end
      end
      rank_new[nw_way] = nw_top;
    end

    ord_new[CNT_W-1:0] = cnt_new;
    for (int i = 0; i < NUM_WAYS; i++) begin
      ord_new[CNT_W + i*RANK_W +: RANK_W]                         = rank_new[i];
      tag_row_new[i*fwctr_pkg::TAG_W +: fwctr_pkg::TAG_W] = tags_new[i];
    end
  end

  // Result register.
  logic                        evicted_q;
  logic [fwctr_pkg::TAG_W-1:0] vtag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      evicted_q <= evict;
      vtag_q    <= vtag;
    end
  end

  assign evicted_o    = evicted_q;
  assign victim_tag_o = vtag_q;

endmodule

// File: design/four_way_cache_tag_replacement.sv
// Requests are handled one at a time: address latch, set read, then compare and
// write back, which waits until the result register is free. For a set count that
// is not a power of two, a quotient step and a remainder step reduce the set index
// modulo the set count between the address latch and the set read.
// Reset: asynchronous, active low; afterwards a clearing pass writes every order row
// while no request is taken. Configuration writes are taken in every cycle.
module four_way_cache_tag_replacement #(
  parameter int NUM_SETS = 1024,
  parameter int NUM_WAYS = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [31:0]                          s_axis_tdata,  // [31:0] address
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [31:0]                          m_axis_tdata,  // [31:0] victim_tag
  output logic                                 m_axis_tuser,  // [0] evicted
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [fwctr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [fwctr_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  fwctr_pkg::cmd_t    cmd;
  fwctr_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  fwctr_ctrl #(
    .NUM_SETS (NUM_SETS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  fwctr_dp #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i & cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .address_i    (s_axis_tdata),
    .cmd_i        (cmd),
    .status_o     (status),
    .evicted_o    (m_axis_tuser),
    .victim_tag_o (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // One request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in work");

  // A pending result is never overwritten by the next one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.update |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result register reloaded while still held");

  // No request is processed during the clearing pass.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_wr |-> !(s_axis_tready || cmd.read || cmd.update))
    else $error("set access during clearing pass");

  // A result without eviction carries a zero tag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("nonzero victim tag without eviction");
`endif

endmodule

// File: bench/four_way_cache_tag_replacement_tb.sv
`timescale 1ns / 100ps

module four_way_cache_tag_replacement_tb;

  localparam int NUM_SETS      = 1024;
  localparam int NUM_WAYS      = 4;
  localparam int SETTLE_CYCLES = 20;
  localparam int QUIET_LIMIT   = 4000;
  localparam int PHASE_ITEMS   = 40;
  localparam int AWAIT_DEPTH   = 64;

  // Codes the package leaves unnamed: a register index and a policy with no meaning.
  localparam logic [fwctr_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [fwctr_pkg::POL_W-1:0]     POL_UNUSED = 2'd3;

  typedef struct packed {
    logic                        evicted;
    logic [fwctr_pkg::TAG_W-1:0] victim_tag;
  } outcome_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid;
  logic                             s_axis_tready;
  logic [31:0]                      s_axis_tdata;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready;
  logic [31:0]                      m_axis_tdata;
  logic                             m_axis_tuser;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [fwctr_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [fwctr_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // Shadow copy of the tag store and its settings.
  logic [fwctr_pkg::TAG_W-1:0] line_tag   [NUM_SETS][NUM_WAYS];
  bit                          line_valid [NUM_SETS][NUM_WAYS];
  logic [7:0]                  way_rank   [NUM_SETS][NUM_WAYS];
  logic [fwctr_pkg::OFF_W-1:0] off_bits;
  logic [fwctr_pkg::SIB_W-1:0] idx_bits;
  logic [fwctr_pkg::POL_W-1:0] policy;

  // Predicted results in request order, as a ring with running counts.
  outcome_t awaited_outcomes [AWAIT_DEPTH];
  int       sent_count;
  int       checked_count;
  outcome_t oldest;
  int       failures;
  int       quiet_cycles;
  bit       idle_on;

  always #5 clk_i = ~clk_i;

  four_way_cache_tag_replacement #(
    .NUM_SETS(NUM_SETS),
    .NUM_WAYS(NUM_WAYS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  function automatic void clear_shadow();
    int s;
    int w;
    for (s = 0; s < NUM_SETS; s++) begin
      for (w = 0; w < NUM_WAYS; w++) begin
        line_tag[s][w]   = '0;
        line_valid[s][w] = 1'b0;
        way_rank[s][w]   = '0;
      end
    end
    off_bits = fwctr_pkg::OFFSET_RESET;
    idx_bits = fwctr_pkg::INDEX_RESET;
    policy   = fwctr_pkg::POL_FIFO;
  endfunction

  // Ways ranked above w move down one step and w becomes the newest.
  function automatic void promote_way(int s, int w, int nvalid);
    logic [7:0] old_rank;
    int i;
    old_rank = way_rank[s][w];
    for (i = 0; i < NUM_WAYS; i++) begin
      if (i != w && line_valid[s][i] && way_rank[s][i] > old_rank) way_rank[s][i]--;
    end
    way_rank[s][w] = 8'(nvalid - 1);
  endfunction

  function automatic outcome_t predict_lookup(logic [31:0] addr);
    logic [63:0] wide;
    logic [63:0] mask;
    logic [fwctr_pkg::TAG_W-1:0] tag;
    logic [7:0] want_rank;
    int s;
    int shift;
    int nvalid;
    int victim;
    int i;
    outcome_t res;
    res    = '0;
    wide   = {32'b0, addr};
    mask   = (64'd1 << idx_bits) - 64'd1;
    s      = int'(((wide >> off_bits) & mask) % 64'(NUM_SETS));
    shift  = int'(off_bits) + int'(idx_bits);
    tag    = 32'(wide >> shift);
    nvalid = 0;
    for (i = 0; i < NUM_WAYS; i++) begin
      if (line_valid[s][i]) nvalid++;
    end
    for (i = 0; i < NUM_WAYS; i++) begin
      if (!line_valid[s][i]) begin
        line_tag[s][i]   = tag;
        line_valid[s][i] = 1'b1;
        way_rank[s][i]   = 8'(nvalid);
        promote_way(s, i, nvalid + 1);
        return res;
      end
      if (line_tag[s][i] == tag) begin
        if (policy == fwctr_pkg::POL_LRU) promote_way(s, i, nvalid);
        return res;
      end
    end
    // Miss in a full set.
    if (policy == POL_UNUSED) return res;
    want_rank = (policy == fwctr_pkg::POL_LIFO) ? 8'(NUM_WAYS - 1) : 8'd0;
    victim = -1;
    for (i = 0; i < NUM_WAYS; i++) begin
      if (victim < 0 && way_rank[s][i] == want_rank) victim = i;
    end
    if (victim < 0) victim = 0;
    res.evicted    = 1'b1;
    res.victim_tag = line_tag[s][victim];
    line_tag[s][victim] = tag;
    promote_way(s, victim, NUM_WAYS);
    return res;
  endfunction

  // Builds an address for the given tag and set under the current settings,
  // with random bits below the set index.
  function automatic logic [31:0] make_addr(logic [31:0] tag, int unsigned set_sel);
    logic [63:0] wide;
    int shift;
    shift = int'(off_bits) + int'(idx_bits);
    wide  = ({32'b0, tag} << shift)
          | ((64'(set_sel) & ((64'd1 << idx_bits) - 64'd1)) << off_bits)
          | (64'($urandom) & ((64'd1 << off_bits) - 64'd1));
    return wide[31:0];
  endfunction

  task automatic send_access(input logic [31:0] addr);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tdata  <= addr;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    awaited_outcomes[sent_count % AWAIT_DEPTH] = predict_lookup(addr);
    sent_count++;
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  // Leaves cfg_valid_i high so that writes can follow back to back.
  task automatic write_reg(input logic [fwctr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fwctr_pkg::CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      fwctr_pkg::REG_OFFSET_BITS: off_bits = val[fwctr_pkg::OFF_W-1:0];
      fwctr_pkg::REG_INDEX_BITS:  idx_bits = val[fwctr_pkg::SIB_W-1:0];
      fwctr_pkg::REG_POLICY:      policy   = val[fwctr_pkg::POL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [fwctr_pkg::OFF_W-1:0] off,
                           input logic [fwctr_pkg::SIB_W-1:0] sib,
                           input logic [fwctr_pkg::POL_W-1:0] pol);
    write_reg(fwctr_pkg::REG_OFFSET_BITS, fwctr_pkg::CFG_DATA_W'(off));
    write_reg(fwctr_pkg::REG_INDEX_BITS, fwctr_pkg::CFG_DATA_W'(sib));
    write_reg(fwctr_pkg::REG_POLICY, fwctr_pkg::CFG_DATA_W'(pol));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sent_count != checked_count) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Reset settings: fill set 0, hit, then a FIFO eviction of the oldest fill.
  task automatic test_fifo_defaults();
    int t;
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    for (t = 1; t < 4; t++) send_access(make_addr(t, 0));
    send_access(make_addr(0, 0));
    send_access(make_addr(4, 0));
    stop_sending();
  endtask

  // A hit refreshes way 0, so the next miss takes the second fill.
  task automatic test_lru_order();
    int t;
    wait_drained();
    configure(5'd4, 4'd6, fwctr_pkg::POL_LRU);
    for (t = 1; t < 5; t++) send_access(make_addr(t, 1));
    send_access(make_addr(1, 1));
    send_access(make_addr(5, 1));
    stop_sending();
  endtask

  task automatic test_lifo_order();
    int t;
    wait_drained();
    configure(5'd4, 4'd6, fwctr_pkg::POL_LIFO);
    for (t = 1; t < 7; t++) send_access(make_addr(t, 2));
    stop_sending();
  endtask

  // Set 0 is full from the first test; a miss there must replace nothing.
  task automatic test_unused_policy();
    wait_drained();
    write_reg(REG_UNUSED, 5'h1F);
    configure(5'd4, 4'd6, POL_UNUSED);
    send_access(make_addr(9, 0));
    send_access(make_addr(2, 0));
    stop_sending();
  endtask

  // Offset and index together pass 32 bits, so every tag is zero.
  task automatic test_wide_shift();
    wait_drained();
    configure(5'd31, 4'd15, fwctr_pkg::POL_LRU);
    send_access(32'h8000_0000);
    send_access(32'h7FFF_FFFF);
    send_access(32'hFFFF_FFFF);
    stop_sending();
  endtask

  task automatic run_random_phase(input logic [fwctr_pkg::OFF_W-1:0] off,
                                  input logic [fwctr_pkg::SIB_W-1:0] sib,
                                  input logic [fwctr_pkg::POL_W-1:0] pol, input int n);
    logic [31:0] tag_pool [6];
    int k;
    int unsigned set_sel;
    for (k = 0; k < 6; k++) tag_pool[k] = $urandom;
    wait_drained();
    configure(off, sib, pol);
    for (k = 0; k < n; k++) begin
      // A few sets, some aliasing above the 1024 real ones, and a handful of tags.
      set_sel = $urandom_range(0, 3) | ($urandom_range(0, 1) << 10);
      if ($urandom_range(0, 4) == 0) send_access($urandom);
      else send_access(make_addr(tag_pool[$urandom_range(0, 5)], set_sel));
    end
    stop_sending();
  endtask

  task automatic test_random_traffic();
    logic [fwctr_pkg::OFF_W-1:0] off;
    logic [fwctr_pkg::SIB_W-1:0] sib;
    logic [fwctr_pkg::POL_W-1:0] pol;
    int p;
    run_random_phase(5'd0, 4'd0, fwctr_pkg::POL_FIFO, PHASE_ITEMS);
    run_random_phase(5'd16, 4'd10, fwctr_pkg::POL_LRU, PHASE_ITEMS);
    run_random_phase(5'd0, 4'd10, fwctr_pkg::POL_LIFO, PHASE_ITEMS);
    run_random_phase(5'd16, 4'd0, fwctr_pkg::POL_FIFO, PHASE_ITEMS);
    run_random_phase(5'd12, 4'd15, fwctr_pkg::POL_LRU, PHASE_ITEMS);
    run_random_phase(5'd31, 4'd1, fwctr_pkg::POL_LIFO, PHASE_ITEMS);
    for (p = 0; p < 6; p++) begin
      off = ($urandom_range(0, 7) == 0) ? fwctr_pkg::OFF_W'($urandom_range(17, 31))
                                        : fwctr_pkg::OFF_W'($urandom_range(0, 16));
      sib = ($urandom_range(0, 7) == 0) ? fwctr_pkg::SIB_W'($urandom_range(11, 15))
                                        : fwctr_pkg::SIB_W'($urandom_range(0, 10));
      pol = ($urandom_range(0, 9) == 0) ? POL_UNUSED
                                        : fwctr_pkg::POL_W'($urandom_range(0, 2));
      // The closing phase runs with both sides at full rate.
      if (p == 5) idle_on = 1'b0;
      run_random_phase(off, sib, pol, PHASE_ITEMS);
    end
  endtask

  // Result side: random stall bursts while idling is enabled.
  always begin
    @(posedge clk_i);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (sent_count == checked_count) begin
        $error("result with no request pending: evicted %0d, victim_tag %08h",
               m_axis_tuser, m_axis_tdata);
        failures++;
      end else begin
        oldest = awaited_outcomes[checked_count % AWAIT_DEPTH];
        checked_count++;
        if (m_axis_tuser !== oldest.evicted) begin
          $error("evicted: expected %0d, got %0d", oldest.evicted, m_axis_tuser);
          failures++;
        end
        if (m_axis_tdata !== oldest.victim_tag) begin
          $error("victim_tag: expected %08h, got %08h", oldest.victim_tag, m_axis_tdata);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    failures      = 0;
    quiet_cycles  = 0;
    sent_count    = 0;
    checked_count = 0;
    idle_on       = 1'b1;
    clear_shadow();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_fifo_defaults();
    test_lru_order();
    test_lifo_order();
    test_unused_policy();
    test_wide_shift();
    test_random_traffic();

    wait_drained();
    if (failures == 0 && sent_count == checked_count) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: four_way_cache_tag_replacement.f
design/fwctr_pkg.sv
design/fwctr_ram.sv
design/fwctr_ctrl.sv
design/fwctr_dp.sv
design/four_way_cache_tag_replacement.sv
bench/four_way_cache_tag_replacement_tb.sv
